/* rtl/core/ais_pkg.sv */
// ais_pkg: shared types and constants of the address interval set
package ais_pkg;

  localparam int MaxRanges = 64;
  localparam int AddrW     = 64;
  localparam int IdxW      = $clog2(MaxRanges);
  localparam int CntW      = $clog2(MaxRanges + 2);

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [IdxW-1:0]  idx_t;

  typedef enum logic [2:0] {
    CmdAdd   = 3'd0,
    CmdSub   = 3'd1,
    CmdFind  = 3'd2,
    CmdIsect = 3'd3,
    CmdClear = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StBadOrder = 2'd1,
    StFull     = 2'd2
  } status_e;

  typedef struct packed {
    addr_t lo;
    addr_t hi;
  } range_t;

  typedef struct packed {
    logic  start;
    logic  ack;
    cmd_e  cmd;
    addr_t lo;
    addr_t hi;
    cnt_t  count;
    logic  bank;
  } scan_req_t;

  typedef struct packed {
    logic  done;
    logic  commit;
    logic  hit;
    logic  full;
    addr_t found_lo;
    addr_t found_hi;
    cnt_t  count;
    addr_t total;
  } scan_rsp_t;

endpackage

/* rtl/core/address_interval_set.sv */
// address_interval_set: top level, command intake, result register and table bookkeeping
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i/in_ready_o  | cmd_i, range_start_i, range_end_i
//   out     | output    | out_valid_o/out_ready_i| changed_o, hit_o, found_start_o,
//           |           |                        | found_end_o, status_o,
//           |           |                        | covered_bytes_o, range_count_o
//
// add, subtract and the two lookups stream the table once through the single read port;
// clear, bad-order add and trivial subtract skip the table pass
// reset empties the table at once; the range memory keeps no reset and needs no sweep
// a new command is taken while a result waits; it completes once the result register frees
module address_interval_set (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [2:0]     cmd_i,
  input  ais_pkg::addr_t range_start_i,
  input  ais_pkg::addr_t range_end_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           changed_o,
  output logic           hit_o,
  output ais_pkg::addr_t found_start_o,
  output ais_pkg::addr_t found_end_o,
  output logic [1:0]     status_o,
  output ais_pkg::addr_t covered_bytes_o,
  output ais_pkg::cnt_t  range_count_o
);
  import ais_pkg::*;

  typedef enum logic [2:0] {
    TIdle = 3'b001,
    TDisp = 3'b010,
    TWait = 3'b100
  } top_state_e;

  top_state_e state_q, state_d;
  cmd_e       cmd_q;
  addr_t      lo_q, hi_q;
  cnt_t       cnt_q, cnt_d;
  addr_t      total_q, total_d;
  logic       bank_q, bank_d;
  logic       ov_q, ov_d;

  logic       chg_q, hit_q;
  addr_t      fs_q, fe_q, cov_q;
  status_e    st_q;
  cnt_t       rc_q;

  logic       ld, ld_chg, ld_hit;
  addr_t      ld_fs, ld_fe;
  status_e    ld_st;
  logic       slot_free, need_eng, accept;

  scan_req_t  req;
  scan_rsp_t  rsp;

  ais_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  assign in_ready_o = state_q == TIdle;
  assign accept     = in_valid_i && in_ready_o;
  assign slot_free  = !ov_q || out_ready_i;

  always_comb begin
    case (cmd_q)
      CmdAdd:            need_eng = lo_q <= hi_q;
      CmdSub:            need_eng = (hi_q > lo_q) && (cnt_q != '0);
      CmdFind, CmdIsect: need_eng = 1'b1;
      default:           need_eng = 1'b0;
    endcase
  end

  always_comb begin
    req.start = (state_q == TDisp) && need_eng;
    req.ack   = (state_q == TWait) && rsp.done && slot_free;
    req.cmd   = cmd_q;
    req.lo    = lo_q;
    req.hi    = hi_q;
    req.count = cnt_q;
    req.bank  = bank_q;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    total_d = total_q;
    bank_d  = bank_q;
    ld      = 1'b0;
    ld_chg  = 1'b0;
    ld_hit  = 1'b0;
    ld_fs   = '0;
    ld_fe   = '0;
    ld_st   = StOk;
    case (state_q)
      TIdle: begin
        if (accept) begin
          state_d = TDisp;
        end
      end
      TDisp: begin
        if (need_eng) begin
          state_d = TWait;
        end else if (slot_free) begin
          ld      = 1'b1;
          state_d = TIdle;
          if ((cmd_q == CmdAdd) && (lo_q > hi_q)) begin
            ld_st = StBadOrder;
          end
          if (cmd_q == CmdClear) begin
            cnt_d   = '0;
            total_d = '0;
          end
        end
      end
      TWait: begin
        if (rsp.done && slot_free) begin
          ld      = 1'b1;
          ld_chg  = rsp.commit;
          ld_hit  = rsp.hit;
          ld_fs   = rsp.found_lo;
          ld_fe   = rsp.found_hi;
          ld_st   = rsp.full ? StFull : StOk;
          state_d = TIdle;
          if (rsp.commit) begin
            cnt_d   = rsp.count;
            total_d = rsp.total;
            bank_d  = ~bank_q;
          end
        end
      end
      default: begin
        state_d = TIdle;
      end
    endcase
    ov_d = ld || (ov_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= TIdle;
      cnt_q   <= '0;
      total_q <= '0;
      bank_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      total_q <= total_d;
      bank_q  <= bank_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_e'(cmd_i);
      lo_q  <= range_start_i;
      hi_q  <= range_end_i;
    end
    if (ld) begin
      chg_q <= ld_chg;
      hit_q <= ld_hit;
      fs_q  <= ld_fs;
      fe_q  <= ld_fe;
      st_q  <= ld_st;
      cov_q <= total_d;
      rc_q  <= cnt_d;
    end
  end

  assign out_valid_o     = ov_q;
  assign changed_o       = chg_q;
  assign hit_o           = hit_q;
  assign found_start_o   = fs_q;
  assign found_end_o     = fe_q;
  assign status_o        = st_q;
  assign covered_bytes_o = cov_q;
  assign range_count_o   = rc_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= cnt_t'(MaxRanges))
    else $error("stored range count above table size");

  a_idle_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == TIdle) |-> !rsp.done)
    else $error("scan result left behind after command finished");

  a_bank_flip_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bank_q != $past(bank_q)) |-> $past(req.ack && rsp.commit))
    else $error("bank swapped without a committed rewrite");

endmodule

/* rtl/core/ais_scan.sv */
// ais_scan: double-banked range table and the streaming pass that rewrites or searches it
module ais_scan (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ais_pkg::scan_req_t req_i,
  output ais_pkg::scan_rsp_t rsp_o
);
  import ais_pkg::*;

  localparam int MemDepth = 2 * MaxRanges;

  typedef enum logic [4:0] {
    SIdle  = 5'b00001,
    SScan  = 5'b00010,
    SFin   = 5'b00100,
    SDrain = 5'b01000,
    SDone  = 5'b10000
  } scan_state_e;

  range_t mem_q [MemDepth];

  scan_state_e state_q, state_d;
  cmd_e   cmd_q, cmd_d;
  addr_t  lo_q, lo_d, hi_q, hi_d;
  cnt_t   cnt_q, cnt_d;
  logic   bank_q, bank_d;
  cnt_t   rd_ptr_q, rd_ptr_d;
  logic   rv_q;
  range_t rdat_q;
  logic   d1v_q;
  range_t d1_q;
  logic   phase_b_q, phase_b_d;
  logic   grow_q, grow_d;
  logic   hv_q, hv_d;
  range_t held_q, held_d;
  cnt_t   w_q, w_d;
  addr_t  sum_q;
  logic   hit_q, hit_d;
  range_t fnd_q, fnd_d;
  logic   chg_q, chg_d;
  logic   abort_q, abort_d;
  logic   wr_v_q, wr_v_d;
  idx_t   wr_idx_q, wr_idx_d;
  range_t wr_dat_q, wr_dat_d;

  logic   rd_en;
  logic   le, last, emit_v, keep;
  range_t emit_r, xr;
  logic   full;

  assign rd_en = (state_q == SScan) && (rd_ptr_q < cnt_q);
  assign le    = d1_q.lo <= lo_q;
  assign last  = le && (!rv_q || (rdat_q.lo > lo_q));

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    cnt_d     = cnt_q;
    bank_d    = bank_q;
    rd_ptr_d  = rd_ptr_q;
    phase_b_d = phase_b_q;
    grow_d    = grow_q;
    hv_d      = hv_q;
    held_d    = held_q;
    w_d       = w_q;
    hit_d     = hit_q;
    fnd_d     = fnd_q;
    chg_d     = chg_q;
    abort_d   = abort_q;
    emit_v    = 1'b0;
    emit_r    = d1_q;
    keep      = 1'b1;
    xr        = d1_q;
    case (state_q)
      SIdle: begin
        if (req_i.start) begin
          cmd_d     = req_i.cmd;
          lo_d      = req_i.lo;
          hi_d      = req_i.hi;
          cnt_d     = req_i.count;
          bank_d    = req_i.bank;
          rd_ptr_d  = '0;
          phase_b_d = 1'b0;
          grow_d    = 1'b0;
          hv_d      = 1'b0;
          w_d       = '0;
          hit_d     = 1'b0;
          fnd_d     = '0;
          chg_d     = 1'b0;
          abort_d   = 1'b0;
          state_d   = SScan;
        end
      end
      SScan: begin
        if (rd_en) begin
          rd_ptr_d = rd_ptr_q + cnt_t'(1);
        end
        if (d1v_q && !abort_q) begin
          case (cmd_q)
            CmdAdd: begin
              if (!phase_b_q) begin
                if (le) begin
                  if (!last) begin
                    emit_v = 1'b1;
                  end else if (d1_q.hi >= lo_q) begin
                    if (d1_q.hi >= hi_q) begin
                      abort_d = 1'b1;
                    end else begin
                      held_d    = '{lo: d1_q.lo, hi: hi_q};
                      hv_d      = 1'b1;
                      grow_d    = 1'b1;
                      phase_b_d = 1'b1;
                    end
                  end else begin
                    emit_v    = 1'b1;
                    held_d    = '{lo: lo_q, hi: hi_q};
                    hv_d      = 1'b1;
                    grow_d    = 1'b1;
                    phase_b_d = 1'b1;
                  end
                end else begin
                  hv_d      = 1'b1;
                  phase_b_d = 1'b1;
                  if (d1_q.lo <= hi_q) begin
                    held_d = '{lo: lo_q, hi: (d1_q.hi > hi_q) ? d1_q.hi : hi_q};
                    grow_d = 1'b1;
                  end else begin
                    emit_v = 1'b1;
                    emit_r = '{lo: lo_q, hi: hi_q};
                    held_d = d1_q;
                    grow_d = 1'b0;
                  end
                end
              end else if (grow_q) begin
                if (d1_q.lo <= held_q.hi) begin
                  if (d1_q.hi > held_q.hi) begin
                    held_d.hi = d1_q.hi;
                  end
                end else begin
                  emit_v = 1'b1;
                  emit_r = held_q;
                  held_d = d1_q;
                  grow_d = 1'b0;
                end
              end else begin
                emit_v = 1'b1;
                emit_r = held_q;
                held_d = d1_q;
              end
            end
            CmdSub: begin
              if (!phase_b_q && le && !last) begin
                emit_v = 1'b1;
              end else if (!phase_b_q && le) begin
                phase_b_d = 1'b1;
                if (d1_q.lo == lo_q) begin
                  chg_d = 1'b1;
                  if (d1_q.hi > hi_q) begin
                    emit_v = 1'b1;
                    emit_r = '{lo: hi_q, hi: d1_q.hi};
                  end
                end else if (d1_q.hi <= lo_q) begin
                  emit_v = 1'b1;
                end else begin
                  chg_d  = 1'b1;
                  emit_v = 1'b1;
                  emit_r = '{lo: d1_q.lo, hi: lo_q};
                  if (d1_q.hi > hi_q) begin
                    held_d = '{lo: hi_q, hi: d1_q.hi};
                    hv_d   = 1'b1;
                  end
                end
              end else begin
                phase_b_d = 1'b1;
                if (d1_q.lo < hi_q) begin
                  chg_d = 1'b1;
                  if (d1_q.hi <= hi_q) begin
                    keep = 1'b0;
                  end else begin
                    xr = '{lo: hi_q, hi: d1_q.hi};
                  end
                end
                if (keep) begin
                  emit_v = 1'b1;
                  if (hv_q) begin
                    emit_r = held_q;
                    held_d = xr;
                  end else begin
                    emit_r = xr;
                  end
                end
              end
            end
            CmdFind, CmdIsect: begin
              if (!phase_b_q) begin
                if (le && last) begin
                  phase_b_d = 1'b1;
                  if (d1_q.hi > lo_q) begin
                    hit_d = 1'b1;
                    fnd_d = d1_q;
                  end else if ((cmd_q == CmdIsect) && rv_q && (rdat_q.lo < hi_q)) begin
                    hit_d = 1'b1;
                    fnd_d = rdat_q;
                  end
                end else if (!le) begin
                  phase_b_d = 1'b1;
                  if ((cmd_q == CmdIsect) && (d1_q.lo < hi_q)) begin
                    hit_d = 1'b1;
                    fnd_d = d1_q;
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
        if (!rd_en && !rv_q && !d1v_q) begin
          state_d = SFin;
        end
      end
      SFin: begin
        if (!abort_q) begin
          if (cmd_q == CmdAdd) begin
            emit_v = 1'b1;
            emit_r = phase_b_q ? held_q : range_t'{lo: lo_q, hi: hi_q};
          end else if ((cmd_q == CmdSub) && hv_q) begin
            emit_v = 1'b1;
            emit_r = held_q;
          end
        end
        state_d = SDrain;
      end
      SDrain: begin
        state_d = SDone;
      end
      SDone: begin
        if (req_i.ack) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
    wr_v_d   = emit_v;
    wr_dat_d = emit_r;
    wr_idx_d = w_q[IdxW-1:0];
    if (emit_v) begin
      w_d = w_q + cnt_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      rv_q      <= 1'b0;
      d1v_q     <= 1'b0;
      wr_v_q    <= 1'b0;
      rd_ptr_q  <= '0;
      cnt_q     <= '0;
      w_q       <= '0;
      sum_q     <= '0;
      phase_b_q <= 1'b0;
      grow_q    <= 1'b0;
      hv_q      <= 1'b0;
      hit_q     <= 1'b0;
      chg_q     <= 1'b0;
      abort_q   <= 1'b0;
      cmd_q     <= CmdAdd;
      bank_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      rv_q      <= rd_en;
      d1v_q     <= rv_q;
      wr_v_q    <= wr_v_d;
      rd_ptr_q  <= rd_ptr_d;
      cnt_q     <= cnt_d;
      w_q       <= w_d;
      phase_b_q <= phase_b_d;
      grow_q    <= grow_d;
      hv_q      <= hv_d;
      hit_q     <= hit_d;
      chg_q     <= chg_d;
      abort_q   <= abort_d;
      cmd_q     <= cmd_d;
      bank_q    <= bank_d;
      if (state_q == SIdle) begin
        sum_q <= '0;
      end else if (wr_v_q) begin
        sum_q <= sum_q + wr_dat_q.hi - wr_dat_q.lo;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    held_q   <= held_d;
    fnd_q    <= fnd_d;
    d1_q     <= rdat_q;
    wr_idx_q <= wr_idx_d;
    wr_dat_q <= wr_dat_d;
  end

  // reads come from the live bank, writes go to the spare one
  always_ff @(posedge clk_i) begin
    if (wr_v_q) begin
      mem_q[{~bank_q, wr_idx_q}] <= wr_dat_q;
    end
    if (rd_en) begin
      rdat_q <= mem_q[{bank_q, rd_ptr_q[IdxW-1:0]}];
    end
  end

  assign full = ((cmd_q == CmdAdd) || (cmd_q == CmdSub)) && !abort_q
                && (w_q > cnt_t'(MaxRanges));

  always_comb begin
    rsp_o.done     = state_q == SDone;
    rsp_o.full     = full;
    rsp_o.commit   = !abort_q && !full
                     && ((cmd_q == CmdAdd) || ((cmd_q == CmdSub) && chg_q));
    rsp_o.hit      = hit_q;
    rsp_o.found_lo = hit_q ? fnd_q.lo : '0;
    rsp_o.found_hi = hit_q ? fnd_q.hi : '0;
    rsp_o.count    = w_q;
    rsp_o.total    = sum_q;
  end

  a_wr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    w_q <= cnt_t'(MaxRanges + 1))
    else $error("write index past one spare entry");

  a_stage_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d1v_q |-> (state_q == SScan))
    else $error("table entry in flight outside scan");

  a_done_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SDone) |-> (!wr_v_q && !rv_q && !d1v_q))
    else $error("result offered while table traffic pending");

endmodule

/* tb/sv/address_interval_set_tb.sv */
// address_interval_set_tb: self-checking testbench of the address interval set
module address_interval_set_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ais_pkg::*;

  typedef struct packed {
    logic          chg;
    logic          hit;
    logic [63:0]   fs;
    logic [63:0]   fe;
    logic [1:0]    st;
    logic [63:0]   total;
    logic [6:0]    cnt;
  } outcome_t;

  class interval_scoreboard;
    logic [63:0] lo_q[$];
    logic [63:0] hi_q[$];
    outcome_t    pending[$];
    int          errors;

    function void reset_table();
      lo_q = {};
      hi_q = {};
    endfunction

    function logic [63:0] sum_bytes();
      logic [63:0] s;
      s = 0;
      foreach (lo_q[k]) s += hi_q[k] - lo_q[k];
      return s;
    endfunction

    function int first_above(logic [63:0] a);
      int i;
      i = 0;
      while (i < lo_q.size() && lo_q[i] <= a) i++;
      return i;
    endfunction

    function int first_at_or_above(logic [63:0] a);
      int i;
      i = 0;
      while (i < lo_q.size() && lo_q[i] < a) i++;
      return i;
    endfunction

    function void merge_add(logic [63:0] s, logic [63:0] e, ref outcome_t r);
      logic [63:0] wl[$];
      logic [63:0] wh[$];
      int nx;
      int p;
      wl = lo_q;
      wh = hi_q;
      nx = first_above(s);
      if (nx > 0 && wh[nx-1] >= s) begin
        p = nx - 1;
        if (wh[p] >= e) return;
        while (nx < wl.size() && wl[nx] <= e) begin
          if (e < wh[nx]) e = wh[nx];
          wl.delete(nx);
          wh.delete(nx);
        end
        wh[p] = e;
        lo_q = wl;
        hi_q = wh;
        r.chg = 1;
        return;
      end
      while (nx < wl.size() && wl[nx] <= e) begin
        if (e < wh[nx]) e = wh[nx];
        wl.delete(nx);
        wh.delete(nx);
      end
      if (wl.size() >= MaxRanges) begin
        r.st = StFull;
        return;
      end
      wl.insert(nx, s);
      wh.insert(nx, e);
      lo_q = wl;
      hi_q = wh;
      r.chg = 1;
    endfunction

    function void cut_range(logic [63:0] s, logic [63:0] e, ref outcome_t r);
      logic [63:0] wl[$];
      logic [63:0] wh[$];
      logic [63:0] top;
      int it;
      int cur;
      bit any;
      bit more;
      if (!(e > s) || lo_q.size() == 0) return;
      wl = lo_q;
      wh = hi_q;
      any = 0;
      it = first_at_or_above(e);
      if (it == 0) return;
      it--;
      forever begin
        if (wl[it] < s) begin
          if (wh[it] <= s) break;
          if (wh[it] <= e) begin
            wh[it] = s;
          end else begin
            if (wl.size() >= MaxRanges) begin
              r.st = StFull;
              return;
            end
            top = wh[it];
            wh[it] = s;
            wl.insert(it + 1, e);
            wh.insert(it + 1, top);
          end
          any = 1;
          break;
        end
        cur = it;
        more = 0;
        if (wl[it] > s && it != 0) begin
          it--;
          more = 1;
        end
        if (wh[cur] <= e) begin
          wl.delete(cur);
          wh.delete(cur);
        end else begin
          wl[cur] = e;
        end
        any = 1;
        if (!more) break;
      end
      if (any) begin
        lo_q = wl;
        hi_q = wh;
        r.chg = 1;
      end
    endfunction

    function void note_command(logic [2:0] c, logic [63:0] s, logic [63:0] e);
      outcome_t r;
      int i;
      r = '0;
      case (c)
        CmdAdd: begin
          if (s > e) r.st = StBadOrder;
          else merge_add(s, e, r);
        end
        CmdSub: cut_range(s, e, r);
        CmdFind: begin
          i = first_above(s);
          if (i > 0 && s < hi_q[i-1]) begin
            r.hit = 1;
            r.fs = lo_q[i-1];
            r.fe = hi_q[i-1];
          end
        end
        CmdIsect: begin
          i = first_above(s);
          if (i > 0 && hi_q[i-1] > s) begin
            r.hit = 1;
            r.fs = lo_q[i-1];
            r.fe = hi_q[i-1];
          end else if (i < lo_q.size() && lo_q[i] < e) begin
            r.hit = 1;
            r.fs = lo_q[i];
            r.fe = hi_q[i];
          end
        end
        CmdClear: reset_table();
        default: ;
      endcase
      r.total = sum_bytes();
      r.cnt = 7'(lo_q.size());
      pending.push_back(r);
    endfunction

    function void check_result(outcome_t got);
      outcome_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  cmd_i;
  addr_t       range_start_i;
  addr_t       range_end_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        changed_o;
  logic        hit_o;
  addr_t       found_start_o;
  addr_t       found_end_o;
  logic [1:0]  status_o;
  addr_t       covered_bytes_o;
  cnt_t        range_count_o;

  interval_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;

  address_interval_set i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .cmd_i           (cmd_i),
    .range_start_i   (range_start_i),
    .range_end_i     (range_end_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .changed_o       (changed_o),
    .hit_o           (hit_o),
    .found_start_o   (found_start_o),
    .found_end_o     (found_end_o),
    .status_o        (status_o),
    .covered_bytes_o (covered_bytes_o),
    .range_count_o   (range_count_o)
  );

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("DONE: errors detected");
    $finish;
  end

  // receiver side: random stall, check on every transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 0;
    end else begin
      if (out_valid_o && out_ready_i)
        sb.check_result({changed_o, hit_o, found_start_o, found_end_o, status_o,
                         covered_bytes_o, 7'(range_count_o)});
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_command(logic [2:0] c, logic [63:0] s, logic [63:0] e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1;
    cmd_i         <= c;
    range_start_i <= s;
    range_end_i   <= e;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_command(c, s, e);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // addresses on a coarse grid so ranges touch, overlap and split often
  function automatic logic [63:0] grid_addr(int span);
    return 64'($urandom_range(span)) * 16 + 64'($urandom_range(2) * 8);
  endfunction

  task automatic random_command();
    logic [63:0] s;
    logic [63:0] e;
    int pick;
    int span;
    pick = $urandom_range(99);
    span = ($urandom_range(3) == 0) ? 400 : 40;
    s = grid_addr(span);
    e = s + 64'($urandom_range(12) * 8);
    if ($urandom_range(19) == 0) begin
      s = rand64();
      e = rand64();
    end
    if (pick < 45) send_command(CmdAdd, s, e);
    else if (pick < 70) send_command(CmdSub, s, e);
    else if (pick < 82) send_command(CmdFind, s, e);
    else if (pick < 94) send_command(CmdIsect, s, e);
    else if (pick < 96) send_command(CmdClear, s, e);
    else if (pick < 98) send_command(CmdAdd, e + 1, s);
    else send_command(3'($urandom_range(7, 5)), s, e);
  endtask

  task automatic run_phase(int n);
    for (int k = 0; k < n; k++) random_command();
  endtask

  initial begin
    logic [63:0] all_ones;
    all_ones = '1;
    sb = new();
    send_idle_pct = 35;
    recv_idle_pct = 81;
    rst_ni = 0;
    in_valid_i = 0;
    cmd_i = CmdClear;
    range_start_i = 0;
    range_end_i = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    send_command(CmdAdd, 100, 200);
    send_command(CmdAdd, 120, 150);
    send_command(CmdAdd, 200, 300);
    send_command(CmdAdd, 400, 400);
    send_command(CmdAdd, 500, 10);
    send_command(CmdSub, 150, 150);
    send_command(CmdSub, 150, 180);
    send_command(CmdSub, 90, 120);
    send_command(CmdSub, 250, 500);
    send_command(CmdFind, 130, 0);
    send_command(CmdFind, 199, 0);
    send_command(CmdIsect, 0, 140);
    send_command(CmdIsect, 260, 0);
    send_command(CmdAdd, 0, all_ones);
    send_command(CmdFind, all_ones - 1, 0);
    send_command(CmdSub, all_ones - 5, all_ones);
    send_command(CmdAdd, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    send_command(3'd5, 1, 2);
    send_command(3'd7, all_ones, all_ones);
    send_command(CmdClear, all_ones, all_ones);
    // fill the table, then overflow it by add and by split
    for (int k = 0; k < MaxRanges; k++) send_command(CmdAdd, k * 10, k * 10 + 4);
    send_command(CmdAdd, 2000, 2004);
    send_command(CmdSub, 1, 2);
    send_command(CmdAdd, 0, 6);
    send_command(CmdSub, 1, 2);
    send_command(CmdClear, 0, 0);

    run_phase(255);
    send_idle_pct = 81;
    recv_idle_pct = 35;
    run_phase(255);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(250);
    in_valid_i <= 0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

/* address_interval_set.f */
rtl/core/ais_pkg.sv
rtl/core/ais_scan.sv
rtl/core/address_interval_set.sv
tb/sv/address_interval_set_tb.sv
